// ===== rtl/zss_pkg.sv =====
`timescale 1ns / 1ps

package zss_pkg;

  localparam int unsigned DIM_W  = 16;
  localparam int unsigned RAW_W  = 34;
  localparam int unsigned ROWB_W = 18;
  localparam int unsigned SUB_W  = 3;
  localparam int unsigned CIDX_W = 8;

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [7:0] ZLIB_CMF    = 8'h78;
  localparam logic [7:0] ZLIB_FLG    = 8'hDA;
  localparam logic [7:0] FILTER_NONE = 8'h00;
  localparam logic [7:0] BTYPE_FINAL = 8'h01;
  localparam logic [7:0] BTYPE_MORE  = 8'h00;

  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

  localparam logic [SUB_W-1:0] SUB_FLG      = 3'd1;
  localparam logic [SUB_W-1:0] SUB_LEN_LO   = 3'd1;
  localparam logic [SUB_W-1:0] SUB_LEN_HI   = 3'd2;
  localparam logic [SUB_W-1:0] SUB_NLEN_LO  = 3'd3;
  localparam logic [SUB_W-1:0] SUB_NLEN_HI  = 3'd4;
  localparam logic [SUB_W-1:0] SUB_BHDR_END = 3'd5;
  localparam logic [SUB_W-1:0] SUB_ADL_H_HI = 3'd0;
  localparam logic [SUB_W-1:0] SUB_ADL_H_LO = 3'd1;
  localparam logic [SUB_W-1:0] SUB_ADL_L_HI = 3'd2;
  localparam logic [SUB_W-1:0] SUB_ADL_L_LO = 3'd3;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             stream_start;
    logic             row_start;
    logic             stream_end;
    logic [RAW_W-1:0] raw_total;
  } item_t;

  typedef enum logic [1:0] {
    BK_EMPTY,
    BK_ZHDR,
    BK_RAW,
    BK_ADLER
  } back_state_e;

  typedef enum logic [1:0] {
    RAW_FILTER,
    RAW_RED,
    RAW_GREEN,
    RAW_BLUE
  } raw_sel_e;

endpackage

// ===== rtl/zlib_stored_image_stream.sv =====
`timescale 1ns / 1ps
// path: the first byte of a pixel passes through the queue, the item register and the output register
// throughput: one output byte per cycle through the byte-wide output register while the
//   sink is ready and the queue holds pixels; 3 bytes per pixel, 4 at a row start, plus 5
//   per stored block, 2 for the stream header and 4 for the adler-32 trailer
// reset: asynchronous, active low; image size returns to 1x1, no stream open
module zlib_stored_image_stream #(
  parameter int unsigned STORED_BLOCK_MAX = 32763,
  parameter int unsigned FIFO_DEPTH       = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [zss_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [zss_pkg::DIM_W-1:0]  cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // red, green, blue
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // out_byte
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser   // stream_done
);

  zss_pkg::item_t push_item, pop_item;
  logic           push, pop, full, empty;

  zss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_data_i  (s_axis_tdata),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  zss_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  zss_back #(
    .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (pop_item),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_user_o  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("stream end byte without last flag");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !s_axis_tready)
    else $error("pixel accepted into full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/zss_front.sv =====
`timescale 1ns / 1ps

module zss_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [zss_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [zss_pkg::DIM_W-1:0]  cfg_data_i,
  input  logic                       pix_valid_i,
  output logic                       pix_ready_o,
  input  logic [23:0]                pix_data_i,
  input  logic                       full_i,
  output logic                       push_o,
  output zss_pkg::item_t             item_o
);

  logic [zss_pkg::DIM_W-1:0] width_q, height_q;
  logic [zss_pkg::DIM_W-1:0] col_q, col_d, row_q, row_d;
  logic                      open_q, open_d;

  logic [zss_pkg::DIM_W-1:0]  w_eff, h_eff, col_cur, row_cur;
  logic [zss_pkg::DIM_W:0]    col_inc, row_inc;
  logic [zss_pkg::ROWB_W-1:0] row_bytes;
  logic [zss_pkg::RAW_W-1:0]  raw_total;
  logic                       row_end, strm_end, accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
    end else if (cfg_valid_i && !open_q) begin
      case (cfg_index_i)
        zss_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        zss_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff     = (width_q == '0) ? 16'd1 : width_q;
    h_eff     = (height_q == '0) ? 16'd1 : height_q;
    col_cur   = open_q ? col_q : '0;
    row_cur   = open_q ? row_q : '0;
    col_inc   = {1'b0, col_cur} + 17'd1;
    row_inc   = {1'b0, row_cur} + 17'd1;
    row_end   = col_inc >= {1'b0, w_eff};
    strm_end  = row_end && (row_inc >= {1'b0, h_eff});
    row_bytes = {1'b0, w_eff, 1'b0} + {2'b0, w_eff} + 18'd1;
    raw_total = {18'b0, h_eff} * {16'b0, row_bytes};
  end

  assign accept      = pix_valid_i && !full_i;
  assign pix_ready_o = !full_i;
  assign push_o      = accept;

  always_comb begin
    item_o.red          = pix_data_i[7:0];
    item_o.green        = pix_data_i[15:8];
    item_o.blue         = pix_data_i[23:16];
    item_o.stream_start = !open_q;
    item_o.row_start    = (col_cur == '0);
    item_o.stream_end   = strm_end;
    item_o.raw_total    = raw_total;
  end

  always_comb begin
    open_d = open_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (strm_end) begin
        open_d = 1'b0;
        col_d  = '0;
        row_d  = '0;
      end else begin
        open_d = 1'b1;
        col_d  = row_end ? '0 : col_inc[zss_pkg::DIM_W-1:0];
        row_d  = row_end ? row_inc[zss_pkg::DIM_W-1:0] : row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      open_q <= open_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

// ===== rtl/zss_fifo.sv =====
`timescale 1ns / 1ps

module zss_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  zss_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output zss_pkg::item_t item_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  zss_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/zss_back.sv =====
`timescale 1ns / 1ps

module zss_back #(
  parameter int unsigned STORED_BLOCK_MAX = 32763
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  zss_pkg::item_t item_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [7:0]     m_data_o,
  output logic           m_last_o,
  output logic           m_user_o
);

  localparam logic [15:0] BLK_MAX = 16'(STORED_BLOCK_MAX);

  zss_pkg::back_state_e state_q, state_d;
  zss_pkg::raw_sel_e    sel_q, sel_d;
  logic [zss_pkg::SUB_W-1:0] sub_q, sub_d;
  zss_pkg::item_t       cur_q, cur_d;

  logic [15:0]               fill_q, a_low_q, a_high_q;
  logic [zss_pkg::RAW_W-1:0] remain_q;

  logic       out_valid_q, out_last_q, out_done_q;
  logic [7:0] out_byte_q;

  logic        adv, step, load;
  logic        valid_c, last_c, done_c, raw_c, item_done_c;
  logic [7:0]  byte_c, raw_byte, bhdr_byte;
  logic [15:0] blk_len, blk_nlen;
  logic        blk_final;
  logic [16:0] fill_inc, s1, s2;
  logic [15:0] low_n, high_n;

  // block header from what is left of the raw data
  always_comb begin
    blk_final = remain_q <= zss_pkg::RAW_W'(STORED_BLOCK_MAX);
    blk_len   = (remain_q < zss_pkg::RAW_W'(STORED_BLOCK_MAX)) ? remain_q[15:0] : BLK_MAX;
    blk_nlen  = ~blk_len;
    case (sub_q)
      zss_pkg::SUB_LEN_LO:  bhdr_byte = blk_len[7:0];
      zss_pkg::SUB_LEN_HI:  bhdr_byte = blk_len[15:8];
      zss_pkg::SUB_NLEN_LO: bhdr_byte = blk_nlen[7:0];
      zss_pkg::SUB_NLEN_HI: bhdr_byte = blk_nlen[15:8];
      default:              bhdr_byte = blk_final ? zss_pkg::BTYPE_FINAL : zss_pkg::BTYPE_MORE;
    endcase
    case (sel_q)
      zss_pkg::RAW_RED:   raw_byte = cur_q.red;
      zss_pkg::RAW_GREEN: raw_byte = cur_q.green;
      zss_pkg::RAW_BLUE:  raw_byte = cur_q.blue;
      default:            raw_byte = zss_pkg::FILTER_NONE;
    endcase
  end

  // byte selection
  always_comb begin
    valid_c     = 1'b1;
    byte_c      = '0;
    last_c      = 1'b0;
    done_c      = 1'b0;
    raw_c       = 1'b0;
    item_done_c = 1'b0;
    case (state_q)
      zss_pkg::BK_ZHDR: begin
        byte_c = (sub_q == zss_pkg::SUB_FLG) ? zss_pkg::ZLIB_FLG : zss_pkg::ZLIB_CMF;
      end
      zss_pkg::BK_RAW: begin
        if (fill_q == '0 && sub_q != zss_pkg::SUB_BHDR_END) begin
          byte_c = bhdr_byte;
        end else begin
          raw_c  = 1'b1;
          byte_c = raw_byte;
          if (sel_q == zss_pkg::RAW_BLUE && !cur_q.stream_end) begin
            last_c      = 1'b1;
            item_done_c = 1'b1;
          end
        end
      end
      zss_pkg::BK_ADLER: begin
        case (sub_q)
          zss_pkg::SUB_ADL_H_HI: byte_c = a_high_q[15:8];
          zss_pkg::SUB_ADL_H_LO: byte_c = a_high_q[7:0];
          zss_pkg::SUB_ADL_L_HI: byte_c = a_low_q[15:8];
          default:               byte_c = a_low_q[7:0];
        endcase
        if (sub_q == zss_pkg::SUB_ADL_L_LO) begin
          last_c      = 1'b1;
          done_c      = 1'b1;
          item_done_c = 1'b1;
        end
      end
      default: valid_c = 1'b0;
    endcase
  end

  assign adv   = !out_valid_q || m_ready_i;
  assign step  = valid_c && adv;
  assign load  = (state_q == zss_pkg::BK_EMPTY || (step && item_done_c)) && !empty_i;
  assign pop_o = load;

  // next state
  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    sel_d   = sel_q;
    cur_d   = cur_q;
    if (step) begin
      case (state_q)
        zss_pkg::BK_ZHDR: begin
          if (sub_q == zss_pkg::SUB_FLG) begin
            state_d = zss_pkg::BK_RAW;
            sub_d   = '0;
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
        zss_pkg::BK_RAW: begin
          if (!raw_c) begin
            sub_d = sub_q + 1'b1;
          end else begin
            sub_d = '0;
            if (sel_q == zss_pkg::RAW_BLUE) begin
              state_d = cur_q.stream_end ? zss_pkg::BK_ADLER : zss_pkg::BK_EMPTY;
            end else begin
              sel_d = zss_pkg::raw_sel_e'(sel_q + 2'd1);
            end
          end
        end
        zss_pkg::BK_ADLER: begin
          if (sub_q == zss_pkg::SUB_ADL_L_LO) begin
            state_d = zss_pkg::BK_EMPTY;
            sub_d   = '0;
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (load) begin
      state_d = item_i.stream_start ? zss_pkg::BK_ZHDR : zss_pkg::BK_RAW;
      sub_d   = '0;
      sel_d   = item_i.row_start ? zss_pkg::RAW_FILTER : zss_pkg::RAW_RED;
      cur_d   = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zss_pkg::BK_EMPTY;
      sub_q   <= '0;
      sel_q   <= zss_pkg::RAW_FILTER;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // adler-32 and block bookkeeping
  always_comb begin
    s1       = {1'b0, a_low_q} + {9'b0, byte_c};
    low_n    = (s1 >= zss_pkg::ADLER_MOD) ? 16'(s1 - zss_pkg::ADLER_MOD) : s1[15:0];
    s2       = {1'b0, a_high_q} + {1'b0, low_n};
    high_n   = (s2 >= zss_pkg::ADLER_MOD) ? 16'(s2 - zss_pkg::ADLER_MOD) : s2[15:0];
    fill_inc = {1'b0, fill_q} + 17'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_low_q  <= 16'd1;
      a_high_q <= '0;
      fill_q   <= '0;
      remain_q <= '0;
    end else begin
      if (load && item_i.stream_start) begin
        a_low_q  <= 16'd1;
        a_high_q <= '0;
        fill_q   <= '0;
        remain_q <= item_i.raw_total;
      end else if (step && done_c) begin
        fill_q   <= '0;
        remain_q <= '0;
      end else if (step && raw_c) begin
        a_low_q  <= low_n;
        a_high_q <= high_n;
        fill_q   <= (fill_inc >= {1'b0, BLK_MAX}) ? '0 : fill_inc[15:0];
        if (remain_q != '0) begin
          remain_q <= remain_q - 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= byte_c;
      out_last_q <= last_c;
      out_done_q <= done_c;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_byte_q;
  assign m_last_o  = out_last_q;
  assign m_user_o  = out_done_q;

endmodule
